@@ src/ils_pkg.sv @@
package ils_pkg;

    localparam int DEPTH = 64;
    localparam int LEN_W = $clog2(DEPTH + 1);
    localparam int POS_W = 6;
    localparam int WORD_W = 32;

    typedef enum logic [2:0] {
        OP_APPEND    = 3'd0,
        OP_OVERWRITE = 3'd1,
        OP_INSERT    = 3'd2,
        OP_REMOVE    = 3'd3,
        OP_DELETE    = 3'd4,
        OP_READ      = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // broadcast to every cell
    typedef struct packed {
        logic             ins;
        logic             del;
        logic             wr;
        logic             rd;
        logic [LEN_W-1:0] pos;
        logic [LEN_W-1:0] rd_idx;
    } cell_cmd_t;

endpackage

@@ src/ils_cell.sv @@
module ils_cell
    import ils_pkg::*;
(
    input  logic                     clk,
    input  logic [LEN_W-1:0]         idx,
    input  cell_cmd_t                cmd,
    input  logic signed [WORD_W-1:0] value_in,
    input  logic signed [WORD_W-1:0] from_below,
    input  logic signed [WORD_W-1:0] from_above,
    output logic signed [WORD_W-1:0] word,
    output logic signed [WORD_W-1:0] rd_word
);

    logic signed [WORD_W-1:0] word_reg;
    logic signed [WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if ((cmd.ins || cmd.wr) && idx == cmd.pos)
        begin
            word_next = value_in;
        end
        else if (cmd.ins && idx > cmd.pos)
        begin
            word_next = from_below;
        end
        else if (cmd.del && idx >= cmd.pos)
        begin
            word_next = from_above;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word    = word_reg;
    assign rd_word = (cmd.rd && idx == cmd.rd_idx) ? word_reg : '0;

endmodule

@@ src/ils_ctrl.sv @@
module ils_ctrl
    import ils_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [2:0]       operation,
    input  logic [POS_W-1:0] position,
    output cell_cmd_t        cmd,
    output status_t          status,
    output logic [LEN_W-1:0] count_next
);

    logic [LEN_W-1:0] count_reg;
    logic [LEN_W-1:0] p;
    logic             full;
    logic             empty;
    logic             inc;
    logic             dec;
    cell_cmd_t        dec_cmd;

    assign p     = LEN_W'(position);
    assign full  = (count_reg == LEN_W'(DEPTH));
    assign empty = (count_reg == '0);

    always_comb
    begin
        dec_cmd = '0;
        status  = ST_OK;
        inc     = 1'b0;
        dec     = 1'b0;
        unique case (operation)
            OP_APPEND:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    dec_cmd.ins = 1'b1;
                    dec_cmd.pos = count_reg;
                    inc         = 1'b1;
                end
            end
            OP_OVERWRITE:
            begin
                if (p < count_reg)
                begin
                    dec_cmd.wr  = 1'b1;
                    dec_cmd.pos = p;
                end
                else if (p > count_reg)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    dec_cmd.ins = 1'b1;
                    dec_cmd.pos = count_reg;
                    inc         = 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (p > count_reg)
                begin
                    status = ST_RANGE;
                end
                else if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    dec_cmd.ins = 1'b1;
                    dec_cmd.pos = p;
                    inc         = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    dec_cmd.rd     = 1'b1;
                    dec_cmd.rd_idx = count_reg - 1'b1;
                    dec            = 1'b1;
                end
            end
            OP_DELETE:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (p >= count_reg)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    dec_cmd.rd     = 1'b1;
                    dec_cmd.rd_idx = p;
                    dec_cmd.del    = 1'b1;
                    dec_cmd.pos    = p;
                    dec            = 1'b1;
                end
            end
            OP_READ:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (p >= count_reg)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    dec_cmd.rd     = 1'b1;
                    dec_cmd.rd_idx = p;
                end
            end
            default:
            begin
                status = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (inc)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (dec)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // cells only move on an accepted word
    always_comb
    begin
        cmd = dec_cmd;
        if (!accept)
        begin
            cmd.ins = 1'b0;
            cmd.del = 1'b0;
            cmd.wr  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= LEN_W'(DEPTH))
        else $error("length above capacity");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status != ST_OK |=> count_reg == $past(count_reg))
        else $error("failed request changed the length");

    a_shift_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.ins && cmd.del))
        else $error("insert and delete shift together");

endmodule

@@ src/indexed_list_store.sv @@
// channel | direction | handshake          | fields
// input   | in        | in_valid/in_stall  | operation, position, value_in
// output  | out       | out_valid/out_stall| value_out, list_length, status
//
// one word per cycle while in_stall is low: each request finishes in the cycle it is taken
// the cell row shifts every later entry in that same cycle
// result shows in the cycle after accept, held in an output register
// in_stall rises only while a result waits under out_stall
// reset clears the length; entry words are not reset
module indexed_list_store
    import ils_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [2:0]               operation,
    input  logic [POS_W-1:0]         position,
    input  logic signed [WORD_W-1:0] value_in,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] value_out,
    output logic [6:0]               list_length,
    output logic [1:0]               status
);

    logic                     accept;
    cell_cmd_t                cmd;
    status_t                  st;
    logic [LEN_W-1:0]         count_next;
    logic signed [WORD_W-1:0] words [DEPTH];
    logic signed [WORD_W-1:0] rd_words [DEPTH];
    logic signed [WORD_W-1:0] rd_value;

    logic                     out_valid_reg;
    logic signed [WORD_W-1:0] value_out_reg;
    logic [6:0]               list_length_reg;
    logic [1:0]               status_reg;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    ils_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .operation  (operation),
        .position   (position),
        .cmd        (cmd),
        .status     (st),
        .count_next (count_next)
    );

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic signed [WORD_W-1:0] below;
            logic signed [WORD_W-1:0] above;

            if (gi == 0)
            begin : g_first
                assign below = '0;
            end
            else
            begin : g_mid_lo
                assign below = words[gi-1];
            end

            if (gi == DEPTH - 1)
            begin : g_last
                assign above = '0;
            end
            else
            begin : g_mid_hi
                assign above = words[gi+1];
            end

            ils_cell u_cell (
                .clk        (clk),
                .idx        (LEN_W'(gi)),
                .cmd        (cmd),
                .value_in   (value_in),
                .from_below (below),
                .from_above (above),
                .word       (words[gi]),
                .rd_word    (rd_words[gi])
            );
        end
    endgenerate

    always_comb
    begin
        rd_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            rd_value = rd_value | rd_words[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            value_out_reg   <= rd_value;
            list_length_reg <= 7'(count_next);
            status_reg      <= st;
        end
    end

    assign out_valid   = out_valid_reg;
    assign value_out   = value_out_reg;
    assign list_length = list_length_reg;
    assign status      = status_reg;

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> value_out == '0)
        else $error("failed request returned a word");

    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_FULL |-> list_length == 7'(DEPTH))
        else $error("full status below capacity");

    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_EMPTY |-> list_length == '0)
        else $error("empty status with entries held");

    a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted word produced no result");

endmodule
